@@ design/lrs_pkg.sv @@
`timescale 1ns / 1ps

package lrs_pkg;

    localparam int ROW_W         = 64;
    localparam int CFG_W         = 7;
    localparam int MAX_WIDTH_DEF = 64;
    localparam int JOB_DEPTH     = 2;
    localparam int RES_DEPTH     = 2;
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_LOW   = 2;
    localparam int SURVIVE_HIGH  = 3;

    typedef struct packed {
        logic [ROW_W-1:0] row_cells;
        logic             last_row;
    } in_item_t;

    typedef struct packed {
        logic [ROW_W-1:0] next_cells;
        logic             frame_end;
    } out_item_t;

    // One queued job: the three-row window for the first result, plus
    // whether a second (bottom-row) result follows from the same window.
    typedef struct packed {
        logic [ROW_W-1:0] above;
        logic [ROW_W-1:0] here;
        logic [ROW_W-1:0] below;
        logic             two_results;
        logic             first_end;
    } job_t;

    // Columns in use; width 0 acts as 1, anything above max_w as max_w.
    function automatic logic [ROW_W-1:0] width_mask(logic [CFG_W-1:0] w,
                                                    int unsigned max_w);
        logic [CFG_W-1:0] ew;
        logic [ROW_W-1:0] m;
        ew = w;
        if (ew == '0)
            ew = CFG_W'(1);
        if (int'(ew) > int'(max_w))
            ew = CFG_W'(max_w);
        for (int k = 0; k < ROW_W; k++)
            m[k] = (k < int'(ew));
        return m;
    endfunction

endpackage

@@ design/lrs_fifo.sv @@
`timescale 1ns / 1ps

module lrs_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

@@ design/lrs_front.sv @@
`timescale 1ns / 1ps

module lrs_front #(
    parameter int MAX_WIDTH = lrs_pkg::MAX_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lrs_pkg::CFG_W-1:0]  row_width,
    input  logic                       push,
    input  lrs_pkg::in_item_t          in_item,
    input  logic                       job_full,
    output logic                       accept,
    output logic                       job_push,
    output lrs_pkg::job_t              job
);
    import lrs_pkg::*;

    logic [ROW_W-1:0] upper_reg, upper_next;
    logic [ROW_W-1:0] middle_reg, middle_next;
    logic [1:0]       rows_seen_reg, rows_seen_next;
    logic [ROW_W-1:0] row;
    logic             have_rows;

    assign accept    = push && !job_full;
    assign row       = in_item.row_cells & width_mask(row_width, MAX_WIDTH);
    // state three never occurs; any nonzero count means a row is held
    assign have_rows = (rows_seen_reg != 2'd0);
    assign job_push  = accept && (have_rows || in_item.last_row);

    always_comb
    begin
        upper_next     = upper_reg;
        middle_next    = middle_reg;
        rows_seen_next = rows_seen_reg;
        if (have_rows)
        begin
            job.above       = upper_reg;
            job.here        = middle_reg;
            job.below       = row;
            job.two_results = in_item.last_row;
            job.first_end   = 1'b0;
        end
        else
        begin
            // single-row frame: dead rows on both sides
            job.above       = '0;
            job.here        = row;
            job.below       = '0;
            job.two_results = 1'b0;
            job.first_end   = 1'b1;
        end
        if (accept)
        begin
            if (in_item.last_row)
            begin
                upper_next     = '0;
                middle_next    = '0;
                rows_seen_next = 2'd0;
            end
            else
            begin
                upper_next     = have_rows ? middle_reg : '0;
                middle_next    = row;
                rows_seen_next = have_rows ? 2'd2 : 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg     <= '0;
            middle_reg    <= '0;
            rows_seen_reg <= 2'd0;
        end
        else
        begin
            upper_reg     <= upper_next;
            middle_reg    <= middle_next;
            rows_seen_reg <= rows_seen_next;
        end
    end

endmodule

@@ design/lrs_back.sv @@
`timescale 1ns / 1ps

module lrs_back #(
    parameter int MAX_WIDTH = lrs_pkg::MAX_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lrs_pkg::CFG_W-1:0]  row_width,
    input  lrs_pkg::job_t              job,
    input  logic                       job_empty,
    output logic                       job_pop,
    output lrs_pkg::out_item_t         out_item,
    output logic                       empty,
    input  logic                       pop
);
    import lrs_pkg::*;

    logic             phase_reg, phase_next;
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] op_a, op_b, op_c;
    logic [ROW_W+1:0] pa, pb, pc;
    logic [ROW_W-1:0] gen;
    logic [3:0]       nbr [ROW_W];
    logic             res_full;
    logic             res_push;
    logic             res_end;
    out_item_t        res;

    assign mask     = width_mask(row_width, MAX_WIDTH);
    assign res_push = !job_empty && !res_full;
    // pop together with the last result of the job
    assign job_pop  = res_push && (phase_reg || !job.two_results);

    always_comb
    begin
        if (phase_reg)
        begin
            op_a    = job.here;
            op_b    = job.below;
            op_c    = '0;
            res_end = 1'b1;
        end
        else
        begin
            op_a    = job.above;
            op_b    = job.here;
            op_c    = job.below;
            res_end = job.first_end;
        end
    end

    // zero pad on both ends: no wrap-around
    assign pa = {1'b0, op_a & mask, 1'b0};
    assign pb = {1'b0, op_b & mask, 1'b0};
    assign pc = {1'b0, op_c & mask, 1'b0};

    always_comb
    begin
        for (int k = 0; k < ROW_W; k++)
        begin
            nbr[k] = 4'(pa[k]) + 4'(pa[k+1]) + 4'(pa[k+2])
                   + 4'(pb[k]) + 4'(pb[k+2])
                   + 4'(pc[k]) + 4'(pc[k+1]) + 4'(pc[k+2]);
            gen[k] = (pb[k+1] && nbr[k] >= 4'(SURVIVE_LOW) && nbr[k] <= 4'(SURVIVE_HIGH))
                   || (!pb[k+1] && nbr[k] == 4'(BIRTH_COUNT));
        end
    end

    assign res = {gen & mask, res_end};

    always_comb
    begin
        phase_next = phase_reg;
        if (res_push)
            phase_next = job.two_results && !phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= 1'b0;
        else
            phase_reg <= phase_next;
    end

    lrs_fifo #(
        .DATA_W ($bits(out_item_t)),
        .DEPTH  (RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (out_item),
        .empty   (empty)
    );

endmodule

@@ design/life_automaton_row_step_unit.sv @@
`timescale 1ns / 1ps

// Channel  | Handshake            | Beat
// ---------+----------------------+-------------------------------------
// input    | push / full          | in_item  : row_cells, last_row
// result   | pop / empty          | out_item : next_cells, frame_end
// config   | cfg_valid / cfg_ready| cfg_data : row_width (reset 64)
//
// Rows in back to back; the front holds the two latest rows and queues window
// jobs, the back gives one B3/S23 result per cycle while a job waits and the
// result queue has room. A frame's first row adds no result, its last row two;
// rows pass the job queue, then the result queue, before empty goes low.
// Async active-low reset clears the rows, the width (to 64) and both queues.
// full follows the job queue; it rises once a full result queue stalls the back.

module life_automaton_row_step_unit #(
    parameter int MAX_WIDTH = lrs_pkg::MAX_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  lrs_pkg::in_item_t         in_item,
    output logic                      empty,
    input  logic                      pop,
    output lrs_pkg::out_item_t        out_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lrs_pkg::CFG_W-1:0] cfg_data
);
    import lrs_pkg::*;

    logic [CFG_W-1:0] row_width_reg;
    logic             accept;
    logic             q_push, q_full, q_pop, q_empty;
    job_t             q_wr_job, q_rd_job;

    // config is to be written only when idle, by the user; not enforced; always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_width_reg <= CFG_W'(64);
        else if (cfg_valid && cfg_ready)
            row_width_reg <= cfg_data;
    end

    assign full = q_full;

    // front: masks the row, tracks the frame, builds window jobs
    lrs_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_width (row_width_reg),
        .push      (push),
        .in_item   (in_item),
        .job_full  (q_full),
        .accept    (accept),
        .job_push  (q_push),
        .job       (q_wr_job)
    );

    // decoupling queue between front and back
    lrs_fifo #(
        .DATA_W ($bits(job_t)),
        .DEPTH  (JOB_DEPTH)
    ) u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_job),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_job),
        .empty   (q_empty)
    );

    // back: next generation per window, result queue to the output
    lrs_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_width (row_width_reg),
        .job       (q_rd_job),
        .job_empty (q_empty),
        .job_pop   (q_pop),
        .out_item  (out_item),
        .empty     (empty),
        .pop       (pop)
    );

`ifndef SYNTHESIS
    a_job_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from empty queue");

    a_job_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (accept && !q_full))
        else $error("job pushed without an accepted row or without room");

    a_last_row_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && in_item.last_row) |=> !q_empty)
        else $error("last row accepted but no job queued");
`endif

endmodule
